// ===== rtl/f32as_pkg.sv =====
`timescale 1ns / 1ps
package f32as_pkg;

  typedef struct packed {
    logic        action;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } f32as_in_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        exponent_out_of_range;
  } f32as_out_t;

  localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
  localparam logic [30:0] MAG_ZERO    = 31'h0;
  localparam logic [7:0]  MAX_GAP     = 8'd40;
  localparam logic [31:0] ROUND_HALF  = 32'h0000_0080;
  localparam logic [30:0] INF_MAG     = 31'h7f80_0000;
  localparam logic [9:0]  EXP_MAX     = 10'sd254;

endpackage

// ===== rtl/f32as_datapath.sv =====
`timescale 1ns / 1ps
module f32as_datapath (
  input  f32as_pkg::f32as_in_t  txn_in,
  output f32as_pkg::f32as_out_t txn_out
);
  import f32as_pkg::*;

  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] big;
  logic [31:0] small_op;
  logic [7:0]  big_exp;
  logic [7:0]  gap;
  logic [31:0] big_man;
  logic [31:0] small_man;
  logic [32:0] man;
  logic [32:0] man_pre;
  logic [5:0]  lz;
  logic [31:0] man_norm;
  logic [32:0] man_rnd;
  logic [23:0] frac_out;
  logic signed [9:0] exp_v;
  logic        found;

  always_comb begin
    a        = txn_in.operand_a;
    b        = txn_in.operand_b ^ (txn_in.action ? SIGN_BIT : 32'h0);
    big      = a;
    small_op = b;
    if (a[30:0] < b[30:0]) begin
      big      = b;
      small_op = a;
    end
    big_exp   = big[30:23];
    gap       = big[30:23] - small_op[30:23];
    big_man   = {1'b1, big[22:0], 8'h0};
    small_man = {1'b1, small_op[22:0], 8'h0} >> gap[5:0];
    // magnitude add or subtract
    if ((big[31] ^ small_op[31]) != 1'b0) begin
      man_pre = {1'b0, big_man} - {1'b0, small_man};
    end else begin
      man_pre = {1'b0, big_man} + {1'b0, small_man};
    end
    // leading-zero count over 32 bits
    lz    = 6'd0;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!found && man_pre[i]) begin
        found = 1'b1;
        lz    = 6'(31 - i);
      end
    end
    // normalize: right by one on carry, else left by leading zeros
    if (man_pre[32]) begin
      man_norm = man_pre[32:1];
      exp_v    = $signed({2'b00, big_exp}) + 10'sd1;
    end else begin
      man_norm = man_pre[31:0] << lz;
      exp_v    = $signed({2'b00, big_exp}) - $signed({4'b0, lz});
    end
    man  = man_pre;
    // round half up on magnitude
    man_rnd = {1'b0, man_norm} + {1'b0, ROUND_HALF};
    if (man_rnd[32]) begin
      frac_out = man_rnd[32:9];
      exp_v    = exp_v + 10'sd1;
    end else begin
      frac_out = man_rnd[31:8];
    end
    // special cases
    if (a[30:0] == MAG_ZERO) begin
      txn_out = '{sum: b, exponent_out_of_range: 1'b0};
    end else if (b[30:0] == MAG_ZERO) begin
      txn_out = '{sum: a, exponent_out_of_range: 1'b0};
    end else if (gap > MAX_GAP) begin
      txn_out = '{sum: big, exponent_out_of_range: 1'b0};
    end else if (man == 33'h0) begin
      txn_out = '{sum: 32'h0, exponent_out_of_range: 1'b0};
    end else if (exp_v > $signed(EXP_MAX)) begin
      txn_out = '{sum: {big[31], INF_MAG}, exponent_out_of_range: 1'b1};
    end else if (exp_v < 10'sd1) begin
      txn_out = '{sum: {big[31], 31'h0}, exponent_out_of_range: 1'b1};
    end else begin
      txn_out = '{sum: {big[31], exp_v[7:0], frac_out[22:0]},
                  exponent_out_of_range: 1'b0};
    end
  end

endmodule

// ===== rtl/float32_add_sub_core.sv =====
`timescale 1ns / 1ps
// float32_add_sub_core: single-precision add / subtract
// input channel: in_data is taken at a rising edge with start high and
//   busy low; busy is always low, so one transaction per cycle is accepted
// result channel: out_data is valid for one cycle while out_valid is high
// pipeline: the input is registered, then one combinational pass feeds the
//   result register; out_valid rises at the edge after the accept edge
// throughput: one transaction every cycle, set by the single-pass datapath
//   between the input and result registers
// reset: rst_n (synchronous, active low) clears the valid bits; payload
//   registers are not reset
// the receiver cannot stall: each result is shown for exactly one cycle
// exponent_out_of_range flags results whose exponent left 1..254; sum is
//   then infinity or signed zero
module float32_add_sub_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  f32as_pkg::f32as_in_t  in_data,
  output logic                  out_valid,
  output f32as_pkg::f32as_out_t out_data
);
  import f32as_pkg::*;

  logic       in_valid_r;
  f32as_in_t  in_r;
  f32as_out_t res_nxt;
  f32as_out_t res_r;
  logic       res_valid_r;

  assign busy = 1'b0;

  // valid bits of the input and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= start;
      res_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      in_r <= in_data;
    end
    res_r <= res_nxt;
  end

  f32as_datapath u_dp (
    .txn_in  (in_r),
    .txn_out (res_nxt)
  );

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

  // result follows each accept, through the input and result registers
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid) else $error("result missing");
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(in_valid_r) |-> !out_valid) else $error("spurious result");
  a_oor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.exponent_out_of_range) |->
      (out_data.sum[30:0] == 31'h0 || out_data.sum[30:0] == INF_MAG))
    else $error("bad out of range pattern");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import f32as_pkg::*;

  // scoreboard: predicts each sum and checks results in order
  class sum_scoreboard;
    f32as_out_t pending_sums[$];
    int mismatches;

    function f32as_out_t predict_sum(f32as_in_t t);
      f32as_out_t r;
      logic [31:0] a, b, big, sml;
      logic [31:0] sgn, big_exp, sml_exp, gap;
      logic [63:0] big_man, sml_man, man;
      int ex;
      int i;
      a = t.operand_a;
      b = t.operand_b;
      r.exponent_out_of_range = 1'b0;
      if (t.action) b = b ^ SIGN_BIT;
      if (a[30:0] == 31'h0) begin
        r.sum = b;
        return r;
      end
      if (b[30:0] == 31'h0) begin
        r.sum = a;
        return r;
      end
      big = a;
      sml = b;
      if (a[30:0] < b[30:0]) begin
        big = b;
        sml = a;
      end
      big_exp = {24'h0, big[30:23]};
      sml_exp = {24'h0, sml[30:23]};
      sgn = big & SIGN_BIT;
      big_man = {40'h0, 1'b1, big[22:0]} << 8;
      sml_man = {40'h0, 1'b1, sml[22:0]} << 8;
      gap = big_exp - sml_exp;
      if (gap > 40) begin
        r.sum = big;
        return r;
      end
      sml_man = sml_man >> gap;
      if (big[31] != sml[31]) man = big_man - sml_man;
      else man = big_man + sml_man;
      if (man == 64'h0) begin
        r.sum = 32'h0;
        return r;
      end
      ex = big_exp;
      for (i = 0; i < 2 && man >= 64'h1_0000_0000; i++) begin
        man = man >> 1;
        ex++;
      end
      for (i = 0; i < 32 && man < 64'h8000_0000; i++) begin
        man = man << 1;
        ex--;
      end
      man = (man + 64'h80) >> 8;
      if (man >= 64'h100_0000) begin
        man = man >> 1;
        ex++;
      end
      if (ex > 254) begin
        r.sum = sgn | {1'b0, INF_MAG};
        r.exponent_out_of_range = 1'b1;
      end else if (ex < 1) begin
        r.sum = sgn;
        r.exponent_out_of_range = 1'b1;
      end else begin
        r.sum = sgn | (ex[7:0] << 23) | {9'h0, man[22:0]};
      end
      return r;
    endfunction

    function void note_operands(f32as_in_t t);
      pending_sums.push_back(predict_sum(t));
    endfunction

    function void check_sum(f32as_out_t got);
      f32as_out_t want;
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result sum=%h flag=%b", got.sum,
                                       got.exponent_out_of_range);
        return;
      end
      want = pending_sums.pop_front();
      if (got.sum !== want.sum ||
          got.exponent_out_of_range !== want.exponent_out_of_range) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected sum=%h flag=%b, got sum=%h flag=%b",
                   want.sum, want.exponent_out_of_range, got.sum,
                   got.exponent_out_of_range);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  f32as_in_t in_data = '0;
  logic out_valid;
  f32as_out_t out_data;
  sum_scoreboard board = new();
  bit gaps_on = 1'b1;

  float32_add_sub_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // monitor: note accepted transactions and check results at the rising edge
  always @(posedge clk) begin
    if (rst_n && start && !busy) board.note_operands(in_data);
    if (rst_n && out_valid) board.check_sum(out_data);
  end

  // drive one transaction, with random idle cycles before it
  task automatic send_op(input logic act, input logic [31:0] a, input logic [31:0] b);
    while (gaps_on && $urandom_range(99) < 15) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= '{action: act, operand_a: a, operand_b: b};
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_float();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0: v[30:23] = 8'h00;
      1: v[30:23] = 8'hff;
      2: v[30:23] = 8'($urandom_range(3));
      3: v[30:23] = 8'hff - 8'($urandom_range(3));
      4: v[30:0] = 31'h0;
      5: v[22:0] = $urandom_range(1) ? 23'h7fffff : 23'h0;
      default: v[30:23] = 8'd100 + 8'($urandom_range(55));
    endcase
    return v;
  endfunction

  initial begin
    logic [31:0] a, b;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed cases
    send_op(1'b0, 32'h0000_0000, 32'hc040_0000);
    send_op(1'b1, 32'h8000_0000, 32'h3f80_0000);
    send_op(1'b0, 32'h4000_0000, 32'h8000_0000);
    send_op(1'b1, 32'h3f80_0000, 32'h3f80_0000);
    send_op(1'b0, 32'h3f80_0000, 32'hbf80_0000);
    send_op(1'b0, 32'h3f80_0000, 32'h3f80_0000);
    send_op(1'b0, 32'h6000_0000, 32'h3f80_0000);
    send_op(1'b1, 32'h3f80_0000, 32'h5000_0000);
    send_op(1'b0, 32'h3f80_0000, 32'h3380_0000);
    send_op(1'b0, 32'h7f7f_ffff, 32'h7f7f_ffff);
    send_op(1'b1, 32'hff7f_ffff, 32'h7f00_0000);
    send_op(1'b1, 32'h0080_0000, 32'h0080_0001);
    send_op(1'b0, 32'h0000_0001, 32'h8000_0003);
    send_op(1'b0, 32'h7f80_0000, 32'h7fc0_0000);
    send_op(1'b1, 32'hffff_ffff, 32'h7fff_ffff);
    send_op(1'b0, 32'h3fff_ffff, 32'h3400_0000);
    send_op(1'b1, 32'h4b80_0000, 32'h3f80_0000);
    send_op(1'b0, 32'hbf80_0000, 32'h3f80_0000);
    // random part, with one long run without idle cycles
    for (int n = 0; n < 1500; n++) begin
      gaps_on = !(n >= 600 && n < 800);
      a = rand_float();
      b = rand_float();
      if ($urandom_range(9) < 3) b[30:23] = a[30:23] + 8'($urandom_range(4)) - 8'd2;
      if ($urandom_range(19) == 0) b = $urandom_range(1) ? a : a ^ SIGN_BIT;
      send_op(1'($urandom_range(1)), a, b);
    end
    start <= 1'b0;
    while (board.pending_sums.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (board.mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #200000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/f32as_pkg.sv
rtl/f32as_datapath.sv
rtl/float32_add_sub_core.sv
verif/tb_top.sv
